FILE: rtl/dlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants for the dashed line rasteriser.
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam int COORD_BITS = 9;
  localparam int COLOR_BITS = 16;
  // error term spans -major .. major, plus sign
  localparam int ERR_BITS   = COORD_BITS + 2;

  localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS + 1;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int DASH_BITS = 2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [COLOR_BITS-1:0]      color_t;
  typedef logic signed [ERR_BITS-1:0] err_t;
  typedef logic [DASH_BITS-1:0]       dash_t;

  typedef struct packed {
    logic   command;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t stroke_color;
    logic   dotted;
  } item_t;

  typedef struct packed {
    coord_t major_pos;
    coord_t major_end;
    coord_t minor_pos;
    err_t   error_term;
    coord_t major_delta;
    coord_t minor_delta;
    logic   minor_decreasing;
    logic   axes_swapped;
  } line_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

endpackage
`default_nettype wire

FILE: rtl/dlr_setup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_setup
// Turns two endpoints into Bresenham line parameters (major axis is the longer of x and y).
// ----------------------------------------------------------------------------
module dlr_setup (
  input  dlr_pkg::coord_t start_x,
  input  dlr_pkg::coord_t start_y,
  input  dlr_pkg::coord_t end_x,
  input  dlr_pkg::coord_t end_y,
  output dlr_pkg::line_t  line
);

  dlr_pkg::coord_t dx;
  dlr_pkg::coord_t dy;
  dlr_pkg::coord_t a_maj;
  dlr_pkg::coord_t a_min;
  dlr_pkg::coord_t b_maj;
  dlr_pkg::coord_t b_min;
  dlr_pkg::coord_t s_min;
  dlr_pkg::coord_t e_min;
  dlr_pkg::coord_t maj_delta;
  logic            steep;
  logic            flip;

  assign dx    = (start_x >= end_x) ? (start_x - end_x) : (end_x - start_x);
  assign dy    = (start_y >= end_y) ? (start_y - end_y) : (end_y - start_y);
  assign steep = dy > dx;

  assign a_maj = steep ? start_y : start_x;
  assign a_min = steep ? start_x : start_y;
  assign b_maj = steep ? end_y : end_x;
  assign b_min = steep ? end_x : end_y;

  // order the endpoints so the major coordinate increases
  assign flip  = a_maj > b_maj;
  assign s_min = flip ? b_min : a_min;
  assign e_min = flip ? a_min : b_min;

  assign maj_delta = steep ? dy : dx;

  always_comb begin
    line.major_pos        = flip ? b_maj : a_maj;
    line.major_end        = flip ? a_maj : b_maj;
    line.minor_pos        = s_min;
    line.major_delta      = maj_delta;
    line.minor_delta      = steep ? dx : dy;
    line.minor_decreasing = e_min < s_min;
    line.axes_swapped     = steep;
    line.error_term       = -$signed(dlr_pkg::ERR_BITS'(maj_delta >> 1));
  end

endmodule
`default_nettype wire

FILE: rtl/dlr_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_engine
// Line state and the per-step Bresenham update with dash pattern.
// ----------------------------------------------------------------------------
module dlr_engine (
  input  wire              clk,
  input  wire              rst,
  input  wire              go,
  input  dlr_pkg::item_t   item,
  input  dlr_pkg::color_t  gap_color,
  output logic             emit,
  output dlr_pkg::pixel_t  pixel
);

  dlr_pkg::line_t  setup;
  dlr_pkg::line_t  line;
  dlr_pkg::line_t  line_next;
  logic            busy;
  logic            dash_enabled;
  dlr_pkg::color_t ink_color;
  dlr_pkg::dash_t  dash_phase;
  dlr_pkg::err_t   err_sum;
  logic            last;
  logic            do_start;

  dlr_setup u_setup (
    .start_x (item.start_x),
    .start_y (item.start_y),
    .end_x   (item.end_x),
    .end_y   (item.end_y),
    .line    (setup)
  );

  assign do_start = go && (item.command == dlr_pkg::CMD_START);
  assign emit     = go && (item.command == dlr_pkg::CMD_STEP) && busy;
  assign last     = line.major_pos == line.major_end;

  assign err_sum = line.error_term
                 + $signed(dlr_pkg::ERR_BITS'(line.minor_delta));

  always_comb begin
    line_next = line;
    if (err_sum > 0) begin
      line_next.minor_pos  = line.minor_decreasing ? (line.minor_pos - 1'b1)
                                                   : (line.minor_pos + 1'b1);
      line_next.error_term = err_sum - $signed(dlr_pkg::ERR_BITS'(line.major_delta));
    end else begin
      line_next.error_term = err_sum;
    end
    if (!last) begin
      line_next.major_pos = line.major_pos + 1'b1;
    end
  end

  always_comb begin
    pixel.x     = line.axes_swapped ? line.minor_pos : line.major_pos;
    pixel.y     = line.axes_swapped ? line.major_pos : line.minor_pos;
    pixel.color = (dash_enabled && (dash_phase != '0)) ? gap_color : ink_color;
    pixel.last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (do_start) begin
      busy <= 1'b1;
    end else if (emit && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      line         <= setup;
      ink_color    <= item.stroke_color;
      dash_enabled <= item.dotted;
      dash_phase   <= '0;
    end else if (emit) begin
      line <= line_next;
      if (dash_enabled) begin
        dash_phase <= dash_phase + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dashed_line_rasterizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A step beat passes through the input register, then the result register, before its
// pixel shows on m_tvalid.
// Throughput: one beat per cycle while the output is not stalled by m_tready.
// A start beat produces no output; a step beat while no line is active is dropped.
// Reset (rst, synchronous) empties both registers, ends any line and clears the
// gap colour to zero.
// ----------------------------------------------------------------------------
// dashed_line_rasterizer_top
// Bresenham line rasteriser with an optional dash pattern: one ink pixel, then three in the gap colour.
// ----------------------------------------------------------------------------
module dashed_line_rasterizer_top (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // start_x, start_y, end_x, end_y, stroke_color, dotted, zero pad
  input  wire  [dlr_pkg::IN_DATA_BITS-1:0]     s_tdata,
  // command
  input  wire                                  s_tuser,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [dlr_pkg::OUT_DATA_BITS-1:0]    m_tdata,
  output logic                                 m_tlast,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [dlr_pkg::COLOR_BITS-1:0]       cfg_data
);

  localparam int CB = dlr_pkg::COORD_BITS;

  logic            in_valid;
  dlr_pkg::item_t  in_item;
  dlr_pkg::item_t  s_item;
  logic            advance;
  logic            emit;
  dlr_pkg::pixel_t pixel;
  dlr_pkg::pixel_t out_pixel;
  dlr_pkg::color_t gap_color;

  always_comb begin
    s_item.command      = s_tuser;
    s_item.start_x      = s_tdata[CB-1:0];
    s_item.start_y      = s_tdata[2*CB-1:CB];
    s_item.end_x        = s_tdata[3*CB-1:2*CB];
    s_item.end_y        = s_tdata[4*CB-1:3*CB];
    s_item.stroke_color = s_tdata[4*CB+dlr_pkg::COLOR_BITS-1:4*CB];
    s_item.dotted       = s_tdata[4*CB+dlr_pkg::COLOR_BITS];
  end

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_color <= '0;
    end else if (cfg_valid && cfg_ready) begin
      gap_color <= cfg_data;
    end
  end

  dlr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .item      (in_item),
    .gap_color (gap_color),
    .emit      (emit),
    .pixel     (pixel)
  );

  // result register: hold the pixel until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel <= pixel;
    end
  end

  assign m_tdata = dlr_pkg::OUT_DATA_BITS'({out_pixel.color, out_pixel.y, out_pixel.x});
  assign m_tlast = out_pixel.last;

endmodule
`default_nettype wire

FILE: rtl/dlr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_checker
// Port-level checks on the rasteriser's stream behaviour.
// ----------------------------------------------------------------------------
module dlr_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               s_tvalid,
  input wire                               s_tready,
  input wire                               s_tuser,
  input wire                               m_tvalid,
  input wire                               m_tready,
  input wire [dlr_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  input wire                               m_tlast
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input side only backs up when the output is stalled
  a_backpressure: assert property (@(posedge clk)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output stall");

  // a fresh pixel comes from an earlier step beat taken on the input
  a_pixel_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |->
      $past(s_tvalid && s_tready && (s_tuser == dlr_pkg::CMD_STEP), 2))
    else $error("pixel without a matching step beat");

endmodule

bind dashed_line_rasterizer_top dlr_checker u_dlr_checker (.*);
`default_nettype wire
